>>> sv/rhi_pkg.sv
`default_nettype none
package rhi_pkg;

  // channel width, quotient bits per division and divider work word
  localparam int ChW = 8;
  localparam int QW = 9;
  localparam int WorkW = ChW + QW;
  localparam int HueW = 9;

  localparam logic [HueW-1:0] HueWrap = 9'd360;
  localparam logic [ChW-1:0] SatFull = 8'd255;
  localparam logic [6:0] HueSector = 7'd60;
  localparam logic [7:0] GreenOffset = 8'd120;
  localparam logic [7:0] BlueOffset = 8'd240;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [ChW-1:0] saturation;
    logic [ChW-1:0] brightness;
  } hsv_t;

  // one item in flight through the divider chain
  typedef struct packed {
    logic grey;
    logic neg;
    logic [ChW-1:0] brightness;
    logic [ChW-1:0] hue_divisor;
    logic [ChW-1:0] sat_divisor;
    logic [WorkW-1:0] hue_work;
    logic [WorkW-1:0] sat_work;
  } cell_data_t;

  // one restoring division step: remainder in the top bits, quotient enters at the bottom
  function automatic logic [WorkW-1:0] div_step(logic [WorkW-1:0] work,
                                                logic [ChW-1:0] divisor);
    logic [ChW:0] trial;
    logic [ChW:0] diff;
    trial = work[WorkW-1:QW-1];
    diff = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      return {diff[ChW-1:0], work[QW-2:0], 1'b1};
    end else begin
      return {trial[ChW-1:0], work[QW-2:0], 1'b0};
    end
  endfunction

endpackage
`default_nettype wire

>>> sv/rhi_prep.sv
`default_nettype none
module rhi_prep (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              src_valid,
  input  wire rhi_pkg::rgb_t     src,
  output logic                   valid,
  output rhi_pkg::cell_data_t    data
);

  logic [rhi_pkg::ChW-1:0] hi;
  logic [rhi_pkg::ChW-1:0] lo;
  logic [rhi_pkg::ChW-1:0] delta;
  logic [rhi_pkg::ChW-1:0] half;
  logic [rhi_pkg::ChW:0] delta_inc;
  logic [rhi_pkg::ChW:0] hi_inc;
  logic [rhi_pkg::ChW-1:0] diff_a;
  logic [rhi_pkg::ChW-1:0] diff_b;
  logic [rhi_pkg::ChW-1:0] offset_mul;
  logic signed [17:0] diff_s;
  logic signed [17:0] num;
  logic [15:0] offset;
  logic [15:0] sat_num;
  logic [16:0] mag;
  rhi_pkg::cell_data_t data_next;

  always_comb begin
    // largest and smallest channel
    hi = (src.red > src.green) ? src.red : src.green;
    hi = (hi > src.blue) ? hi : src.blue;
    lo = (src.red < src.green) ? src.red : src.green;
    lo = (lo < src.blue) ? lo : src.blue;
    delta = hi - lo;
    delta_inc = {1'b0, delta} + 9'd1;
    half = delta_inc[rhi_pkg::ChW:1];
    hi_inc = {1'b0, hi} + 9'd1;

    // hue branch, ties go red then green then blue
    if (src.red == hi) begin
      diff_a = src.green;
      diff_b = src.blue;
      offset_mul = 8'd0;
    end else if (src.green == hi) begin
      diff_a = src.blue;
      diff_b = src.red;
      offset_mul = rhi_pkg::GreenOffset;
    end else begin
      diff_a = src.red;
      diff_b = src.green;
      offset_mul = rhi_pkg::BlueOffset;
    end

    // signed hue numerator and its magnitude
    diff_s = $signed({10'd0, diff_a}) - $signed({10'd0, diff_b});
    offset = delta * offset_mul;
    num = diff_s * $signed({11'd0, rhi_pkg::HueSector})
          + $signed({10'd0, half}) + $signed({2'b0, offset});
    mag = num[17] ? 17'(-num) : num[16:0];

    // saturation numerator
    sat_num = {8'd0, lo} * {8'd0, rhi_pkg::SatFull} + {8'd0, hi_inc[rhi_pkg::ChW:1]};

    data_next.grey = (delta == '0);
    data_next.neg = num[17];
    data_next.brightness = hi;
    data_next.hue_divisor = delta;
    data_next.sat_divisor = hi;
    data_next.hue_work = mag;
    data_next.sat_work = {1'b0, sat_num};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/rhi_cell.sv
`default_nettype none
module rhi_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                src_valid,
  input  wire rhi_pkg::cell_data_t src,
  output logic                     valid,
  output rhi_pkg::cell_data_t      data
);

  rhi_pkg::cell_data_t data_next;

  // one quotient bit for hue and one for saturation
  always_comb begin
    data_next = src;
    data_next.hue_work = rhi_pkg::div_step(src.hue_work, src.hue_divisor);
    data_next.sat_work = rhi_pkg::div_step(src.sat_work, src.sat_divisor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/rgb_to_hsv_integer_unit.sv
`default_nettype none
// Integer RGB to HSV conversion of 8-bit pixels. The unit accepts one pixel
// every clock while its output register is not held; each result passes these stages:
// the channel extremes and the two numerators are registered at the accepting
// edge, then pass through a row of restoring divider cells, each
// retiring one quotient bit of the hue and of the saturation division, and
// finally into the output register.
// The whole pipeline holds while a result waits at the output, so pixel_ready
// follows hsv_ready whenever the output register is full. Grey pixels give
// hue 0 and saturation 0; brightness is the largest channel.
module rgb_to_hsv_integer_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pixel_valid,
  output logic                pixel_ready,
  input  wire rhi_pkg::rgb_t  pixel,
  output logic                hsv_valid,
  input  wire logic           hsv_ready,
  output rhi_pkg::hsv_t       hsv
);

  logic en;
  logic [rhi_pkg::QW:0] stage_valid;
  rhi_pkg::cell_data_t stage [rhi_pkg::QW+1];
  rhi_pkg::cell_data_t last;
  logic [rhi_pkg::QW-1:0] hue_q;
  logic [rhi_pkg::QW-1:0] sat_q;
  rhi_pkg::hsv_t hsv_next;

  // pipeline advances while the output is empty or being taken
  assign en = !hsv_valid || hsv_ready;
  assign pixel_ready = en;

  rhi_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .src_valid (pixel_valid),
    .src       (pixel),
    .valid     (stage_valid[0]),
    .data      (stage[0])
  );

  // divider chain, most significant quotient bit first
  for (genvar i = 0; i < rhi_pkg::QW; i++) begin : g_cell
    rhi_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .src_valid (stage_valid[i]),
      .src       (stage[i]),
      .valid     (stage_valid[i+1]),
      .data      (stage[i+1])
    );
  end

  // wrap negative hue, complement saturation, mask grey pixels
  always_comb begin
    last = stage[rhi_pkg::QW];
    hue_q = last.hue_work[rhi_pkg::QW-1:0];
    sat_q = last.sat_work[rhi_pkg::QW-1:0];
    hsv_next.brightness = last.brightness;
    if (last.grey) begin
      hsv_next.hue = '0;
      hsv_next.saturation = '0;
    end else begin
      hsv_next.hue = (last.neg && hue_q != '0) ? rhi_pkg::HueWrap - hue_q : hue_q;
      hsv_next.saturation = rhi_pkg::SatFull - sat_q[rhi_pkg::ChW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
    end else if (en) begin
      hsv_valid <= stage_valid[rhi_pkg::QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsv <= hsv_next;
    end
  end

`ifndef SYNTHESIS
  // hue never leaves its range
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hsv.hue < rhi_pkg::HueWrap)
    else $error("hue out of range");

  // zero saturation only for grey pixels, which carry zero hue
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv.saturation == '0 |-> hsv.hue == '0)
    else $error("zero saturation with nonzero hue");

  // an accepted item enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> stage_valid[0])
    else $error("accepted item lost at pipeline entry");
`endif

endmodule
`default_nettype wire

>>> verif/tb_rgb_to_hsv_integer_unit.sv
`timescale 1ns / 1ps

// expected hsv values for accepted pixels, in order, and the running mismatch count
class hsv_ledger;
  rhi_pkg::hsv_t pending_hsv[$];
  int mismatches = 0;

  // integer conversion of one pixel, truncating hue division toward zero
  function rhi_pkg::hsv_t hsv_of(rhi_pkg::rgb_t p);
    int r, g, b, hi, lo, delta, half, num, q;
    rhi_pkg::hsv_t res;
    r = int'(p.red);
    g = int'(p.green);
    b = int'(p.blue);
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    delta = hi - lo;
    res = '0;
    res.brightness = 8'(hi);
    if (delta != 0) begin
      half = (delta + 1) >> 1;
      res.saturation = 8'(255 - (255 * lo + ((hi + 1) >> 1)) / hi);
      // ties resolve red, then green, then blue
      if (r == hi) begin
        num = 60 * (g - b) + half;
      end else if (g == hi) begin
        num = 60 * (b - r) + half + 120 * delta;
      end else begin
        num = 60 * (r - g) + half + 240 * delta;
      end
      q = num / delta;
      if (q < 0) q += 360;
      res.hue = 9'(q);
    end
    return res;
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  function void note_pixel(rhi_pkg::rgb_t p);
    pending_hsv.push_back(hsv_of(p));
  endfunction

  task check_hsv(rhi_pkg::hsv_t got);
    rhi_pkg::hsv_t want;
    if (pending_hsv.size() == 0) begin
      report_mismatch($sformatf("result h=%0d s=%0d v=%0d with no pixel pending",
                                got.hue, got.saturation, got.brightness));
    end else begin
      want = pending_hsv.pop_front();
      if (got.hue != want.hue)
        report_mismatch($sformatf("hue %0d, expected %0d", got.hue, want.hue));
      if (got.saturation != want.saturation)
        report_mismatch($sformatf("saturation %0d, expected %0d",
                                  got.saturation, want.saturation));
      if (got.brightness != want.brightness)
        report_mismatch($sformatf("brightness %0d, expected %0d",
                                  got.brightness, want.brightness));
    end
  endtask
endclass

module tb_rgb_to_hsv_integer_unit;

  // corner pixels as {red, green, blue}
  localparam logic [23:0] CORNER_PIXELS [24] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'hFF0001, 24'hFF0055,
    24'hC83296, 24'h32C864, 24'h0A14FA, 24'hFF8000, 24'h010000, 24'h000100,
    24'h000001, 24'hFFFEFE, 24'h7F80FF, 24'h01FF00, 24'hAA55AA, 24'h020001
  };
  localparam int ItemsPerPhase = 80;
  localparam int HoldCycles = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_ready;
  rhi_pkg::rgb_t pixel = '0;
  logic hsv_valid;
  logic hsv_ready = 1'b0;
  rhi_pkg::hsv_t hsv;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  hsv_ledger book;

  rgb_to_hsv_integer_unit dut (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel(pixel),
    .hsv_valid(hsv_valid),
    .hsv_ready(hsv_ready),
    .hsv(hsv)
  );

  always #10 clk = ~clk;

  // offer one item, idling first at the current rate, and wait for acceptance
  task automatic send_pixel(rhi_pkg::rgb_t p);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
  endtask

  // mix of plain random pixels and the shapes that reach the special branches
  function automatic rhi_pkg::rgb_t random_pixel();
    logic [7:0] v, w, x;
    logic [7:0] ends [6];
    rhi_pkg::rgb_t p;
    ends = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    v = 8'($urandom_range(255));
    w = 8'($urandom_range(255));
    x = 8'($urandom_range(255));
    case ($urandom_range(9))
      5: p = '{v, v, v};
      6: begin
        case ($urandom_range(2))
          0: p = '{v, v, w};
          1: p = '{v, w, v};
          default: p = '{w, v, v};
        endcase
      end
      7: begin
        // red on top with blue above green: a negative quotient here wraps
        p.green = 8'($urandom_range(253));
        p.blue = 8'($urandom_range(254, int'(p.green) + 1));
        p.red = 8'($urandom_range(255, int'(p.blue) + 1));
      end
      8: p = '{ends[$urandom_range(5)], ends[$urandom_range(5)], ends[$urandom_range(5)]};
      9: begin
        p = '{v, w, x};
        case ($urandom_range(2))
          0: p.red = $urandom_range(1) ? 8'd255 : 8'd0;
          1: p.green = $urandom_range(1) ? 8'd255 : 8'd0;
          default: p.blue = $urandom_range(1) ? 8'd255 : 8'd0;
        endcase
      end
      default: p = '{v, w, x};
    endcase
    return p;
  endfunction

  // receiver: random stalls, or a long hold-off counted here
  always @(posedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      hsv_ready <= 1'b0;
    end else begin
      hsv_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // note accepted pixels and check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && pixel_ready) book.note_pixel(pixel);
      if (hsv_valid && hsv_ready) book.check_hsv(hsv);
    end
  end

  initial begin
    book = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners, no idling
    foreach (CORNER_PIXELS[i]) send_pixel(rhi_pkg::rgb_t'(CORNER_PIXELS[i]));

    // random phases with different idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_request = 1'b1;
        end
        1: begin
          send_idle_pct = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 67;
        end
        3: begin
          send_idle_pct = 26;
          recv_stall_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (ItemsPerPhase) send_pixel(random_pixel());
    end
    pixel_valid <= 1'b0;

    // drain, then wait on past the pipeline depth
    while (book.pending_hsv.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #(200000 * 20);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
